>>> rtl/bcc_pkg.sv
// shared types and constants for the button click classifier
// no dependencies; imported by bcc_tick, bcc_evq and button_click_classifier_core

package bcc_pkg;

   localparam int EvSlots = 3;
   localparam int EvCands = 5;

   typedef enum logic [1:0] {
      ARM_OFF     = 2'd0,
      ARM_FALLING = 2'd1,
      ARM_RISING  = 2'd2
   } arm_type;

   typedef enum logic [2:0] {
      KIND_NONE   = 3'd0,
      KIND_CLICK  = 3'd1,
      KIND_FIRST  = 3'd2,
      KIND_DOUBLE = 3'd3,
      KIND_LONG   = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      EV_IDLE_OFF  = 3'd0,
      EV_IDLE_ON   = 3'd1,
      EV_SHORT     = 3'd2,
      EV_DOUBLE    = 3'd3,
      EV_LONG      = 3'd4,
      EV_STATE_ON  = 3'd5,
      EV_STATE_OFF = 3'd6
   } event_type;

   typedef enum logic [2:0] {
      CSR_DOUBLE_PRESS_LIMIT = 3'd0,
      CSR_LONG_PRESS_LIMIT   = 3'd1,
      CSR_DOUBLE_WINDOW      = 3'd2,
      CSR_DEBOUNCE_TIME      = 3'd3,
      CSR_IDLE_TIME          = 3'd4
   } csr_index_type;

   localparam logic [15:0] DoublePressLimitReset = 16'd200;
   localparam logic [15:0] LongPressLimitReset   = 16'd1000;
   localparam logic [15:0] DoubleWindowReset     = 16'd500;
   localparam logic [15:0] DebounceTimeReset     = 16'd50;
   localparam logic [23:0] IdleTimeReset         = 24'd60000;

   typedef struct packed {
      logic [15:0] double_press_limit;
      logic [15:0] long_press_limit;
      logic [15:0] double_window;
      logic [15:0] debounce_time;
      logic [23:0] idle_time;
   } cfg_type;

   // events produced by one tick, slot 0 goes out first
   typedef struct packed {
      logic [1:0]                 count;
      logic [EvSlots-1:0][2:0]    code;
   } ev_bundle_type;

endpackage

>>> rtl/bcc_tick.sv
// classifier state and the per-tick update logic
// depends on bcc_pkg

module bcc_tick (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   go,
   input  logic                   pin_level,
   input  logic                   fell,
   input  logic                   rose,
   input  bcc_pkg::cfg_type       cfg,
   output bcc_pkg::ev_bundle_type ev
);
   import bcc_pkg::*;

   arm_type     armed_ff, armed_in;
   logic        idle_flag_ff, idle_flag_in;
   logic [23:0] idle_elapsed_ff, idle_elapsed_in;
   logic        press_active_ff, press_active_in;
   logic [15:0] press_elapsed_ff, press_elapsed_in;
   logic        deb_active_ff, deb_active_in;
   logic [15:0] deb_elapsed_ff, deb_elapsed_in;
   logic [15:0] dbl_elapsed_ff, dbl_elapsed_in;
   kind_type    kind_ff, kind_in;

   logic [EvCands-1:0]      cand_v;
   logic [EvCands-1:0][2:0] cand_c;

   always_comb begin
      logic hit;
      logic [1:0] n;
      armed_in         = armed_ff;
      idle_flag_in     = idle_flag_ff;
      press_active_in  = press_active_ff;
      deb_active_in    = deb_active_ff;
      kind_in          = kind_ff;
      cand_v           = '0;
      cand_c           = '0;
      // all counters advance first, saturating
      press_elapsed_in = press_elapsed_ff;
      if (press_active_ff && press_elapsed_ff != 16'hFFFF) begin
         press_elapsed_in = press_elapsed_ff + 16'd1;
      end
      deb_elapsed_in = deb_elapsed_ff;
      if (deb_active_ff && deb_elapsed_ff != 16'hFFFF) begin
         deb_elapsed_in = deb_elapsed_ff + 16'd1;
      end
      dbl_elapsed_in = (dbl_elapsed_ff == 16'hFFFF) ? dbl_elapsed_ff : dbl_elapsed_ff + 16'd1;
      idle_elapsed_in = (idle_elapsed_ff == 24'hFFFFFF) ? idle_elapsed_ff
                                                         : idle_elapsed_ff + 24'd1;

      hit = (armed_ff == ARM_FALLING && fell) || (armed_ff == ARM_RISING && rose);

      // counted edge
      if (hit) begin
         armed_in = ARM_OFF;
         if (idle_flag_ff) begin
            idle_flag_in = 1'b0;
            cand_v[0]    = 1'b1;
            cand_c[0]    = EV_IDLE_OFF;
         end
         idle_elapsed_in = '0;
         deb_active_in   = 1'b1;
         deb_elapsed_in  = '0;
         if (!press_active_ff) begin
            press_active_in  = 1'b1;
            press_elapsed_in = '0;
         end else begin
            if (press_elapsed_in < cfg.double_press_limit) begin
               if (kind_ff == KIND_FIRST) begin
                  kind_in   = KIND_DOUBLE;
                  cand_v[1] = 1'b1;
                  cand_c[1] = EV_DOUBLE;
               end else begin
                  kind_in        = KIND_FIRST;
                  dbl_elapsed_in = '0;
               end
            end else begin
               kind_in   = KIND_CLICK;
               cand_v[1] = 1'b1;
               cand_c[1] = EV_SHORT;
            end
            press_active_in = 1'b0;
            armed_in        = ARM_FALLING;
         end
      end

      // long press
      if (press_active_in && press_elapsed_in > cfg.long_press_limit) begin
         kind_in         = KIND_LONG;
         press_active_in = 1'b0;
         cand_v[2]       = 1'b1;
         cand_c[2]       = EV_LONG;
      end

      // pending first half of a double expires
      if (kind_in == KIND_FIRST && dbl_elapsed_in > cfg.double_window) begin
         kind_in = KIND_NONE;
      end

      // debounce done, sample the pin
      if (deb_active_in && deb_elapsed_in > cfg.debounce_time) begin
         deb_active_in = 1'b0;
         cand_v[3]     = 1'b1;
         if (!pin_level) begin
            cand_c[3] = EV_STATE_ON;
            armed_in  = ARM_RISING;
         end else begin
            cand_c[3]       = EV_STATE_OFF;
            press_active_in = 1'b0;
            armed_in        = ARM_FALLING;
         end
      end

      // idle
      if (!idle_flag_in && idle_elapsed_in > cfg.idle_time) begin
         idle_elapsed_in = '0;
         idle_flag_in    = 1'b1;
         cand_v[4]       = 1'b1;
         cand_c[4]       = EV_IDLE_ON;
      end

      // pack candidate events into output slots in order
      n       = '0;
      ev.code = '0;
      for (int i = 0; i < EvCands; i++) begin
         if (cand_v[i] && n < 2'd3) begin
            ev.code[n] = cand_c[i];
            n          = n + 2'd1;
         end
      end
      ev.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff         <= ARM_FALLING;
         idle_flag_ff     <= 1'b0;
         idle_elapsed_ff  <= '0;
         press_active_ff  <= 1'b0;
         press_elapsed_ff <= '0;
         deb_active_ff    <= 1'b0;
         deb_elapsed_ff   <= '0;
         dbl_elapsed_ff   <= '0;
         kind_ff          <= KIND_NONE;
      end else if (go) begin
         armed_ff         <= armed_in;
         idle_flag_ff     <= idle_flag_in;
         idle_elapsed_ff  <= idle_elapsed_in;
         press_active_ff  <= press_active_in;
         press_elapsed_ff <= press_elapsed_in;
         deb_active_ff    <= deb_active_in;
         deb_elapsed_ff   <= deb_elapsed_in;
         dbl_elapsed_ff   <= dbl_elapsed_in;
         kind_ff          <= kind_in;
      end
   end

endmodule

>>> rtl/bcc_evq.sv
// result register holding the events of one tick, drained one beat a cycle while out_stall is low
// depends on bcc_pkg

module bcc_evq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  bcc_pkg::ev_bundle_type ev,
   output logic                   free,
   output logic                   out_valid,
   input  logic                   out_stall,
   output logic [2:0]             out_code,
   output logic                   out_last
);
   import bcc_pkg::*;

   logic [1:0]              cnt_ff, cnt_in;
   logic [EvSlots-1:0][2:0] slot_ff, slot_in;
   logic                    pop;

   assign pop       = out_valid && !out_stall;
   assign out_valid = (cnt_ff != 2'd0);
   assign out_code  = slot_ff[0];
   assign out_last  = (cnt_ff == 2'd1);
   // empty, or the last beat leaves this cycle
   assign free      = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop);

   always_comb begin
      cnt_in  = cnt_ff;
      slot_in = slot_ff;
      if (load) begin
         cnt_in  = ev.count;
         slot_in = ev.code;
      end else if (pop) begin
         cnt_in = cnt_ff - 2'd1;
         for (int i = 0; i < EvSlots - 1; i++) begin
            slot_in[i] = slot_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

>>> rtl/button_click_classifier_core.sv
// top level of the debounced push-button click classifier
// depends on bcc_pkg, bcc_tick and bcc_evq
//  - req channel: one beat per millisecond tick with the sampled pin level
//    (active low) and the falling / rising edges seen since the last tick
//  - rsp channel: zero to three event beats per tick, in order; last_of_run
//    marks the final event of a tick, a tick that causes no event gives no beat
//  - csr channel: index 0..4 selects double_press_limit, long_press_limit,
//    double_window, debounce_time, idle_time; csr_ready is always high and
//    unknown indexes are dropped; write only while the block is idle
//  - path: a tick accepted into the input register updates the state and loads
//    the result register once that register is free; its events leave from there
//  - throughput: one tick per cycle while each tick gives at most one event and
//    rsp_stall is low; a tick with more events holds the result register until
//    its last event is taken, the next tick is processed in the cycle it is taken
//  - the tick input register and the result register are separate, so a new
//    tick is taken while the previous tick's events still wait
//  - rsp_stall freezes the result register; once the input register is full
//    and cannot be processed, req_stall rises
//  - reset clears the classifier state (armed on falling edge, no press, no
//    idle) and restores the register defaults; no clearing pass is needed

module button_click_classifier_core (
   input  logic        clock,
   input  logic        reset,
   // tick input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_pin_level,
   input  logic        req_fell,
   input  logic        req_rose,
   // event output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_code,
   output logic        rsp_last_of_run,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);
   import bcc_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   logic          in_valid_ff, in_valid_in;
   logic          in_pin_ff, in_fell_ff, in_rose_ff;
   logic          req_take;
   logic          q_free;
   logic          go;
   ev_bundle_type ev;

   // config registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DOUBLE_PRESS_LIMIT: cfg_in.double_press_limit = csr_data[15:0];
            CSR_LONG_PRESS_LIMIT:   cfg_in.long_press_limit   = csr_data[15:0];
            CSR_DOUBLE_WINDOW:      cfg_in.double_window      = csr_data[15:0];
            CSR_DEBOUNCE_TIME:      cfg_in.debounce_time      = csr_data[15:0];
            CSR_IDLE_TIME:          cfg_in.idle_time          = csr_data;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.double_press_limit <= DoublePressLimitReset;
         cfg_ff.long_press_limit   <= LongPressLimitReset;
         cfg_ff.double_window      <= DoubleWindowReset;
         cfg_ff.debounce_time      <= DebounceTimeReset;
         cfg_ff.idle_time          <= IdleTimeReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // tick input register, processed once the result register can take it
   assign go        = in_valid_ff && q_free;
   assign req_stall = in_valid_ff && !go;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (go) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_pin_ff  <= req_pin_level;
         in_fell_ff <= req_fell;
         in_rose_ff <= req_rose;
      end
   end

   // classifier state and update
   bcc_tick u_tick (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .pin_level (in_pin_ff),
      .fell      (in_fell_ff),
      .rose      (in_rose_ff),
      .cfg       (cfg_ff),
      .ev        (ev)
   );

   // result register, one event beat per cycle while rsp_stall is low
   bcc_evq u_evq (
      .clock     (clock),
      .reset     (reset),
      .load      (go),
      .ev        (ev),
      .free      (q_free),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_code  (rsp_event_code),
      .out_last  (rsp_last_of_run)
   );

endmodule

>>> rtl/bcc_checker.sv
// port-level checks for the button click classifier
// depends on button_click_classifier_core; bound to it below

module bcc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_event_code,
   input logic       rsp_last_of_run
);

   // nothing pending right after reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("outputs not idle after reset");

   // a tick's events come out back to back until the last one
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_run |=> rsp_valid)
      else $error("event run broken before its last beat");

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_code)
                                 && $stable(rsp_last_of_run))
      else $error("stalled result beat changed");

   // no undefined event code on a beat
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_code != 3'd7)
      else $error("undefined event code");

endmodule

bind button_click_classifier_core bcc_checker u_bcc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_event_code  (rsp_event_code),
   .rsp_last_of_run (rsp_last_of_run)
);
